// File: sv/assert_macros.svh
// Assertion helpers; the module using them must have clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define HOE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define HOE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/hoe_pkg.sv
package hoe_pkg;

    typedef struct packed {
        logic signed [31:0] q_x;
        logic signed [31:0] q_y;
        logic signed [31:0] q_z;
        logic [1:0]         orbital;
    } in_t;

    typedef struct packed {
        logic signed [31:0] psi;
        logic               saturated;
    } out_t;

    // Classified item as queued between front and back.
    typedef struct packed {
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic        is_s;
        logic        pneg;
        logic [31:0] pmag;
    } cls_t;

    // Sideband carried through the divider.
    typedef struct packed {
        logic rneg;
        logic zero;
    } side_t;

    localparam logic [1:0] ORB_2S  = 2'd0;
    localparam logic [1:0] ORB_2PX = 2'd1;
    localparam logic [1:0] ORB_2PY = 2'd2;
    localparam logic [1:0] ORB_2PZ = 2'd3;

    localparam logic [1:0] CFG_ZEFF   = 2'd0;
    localparam logic [1:0] CFG_NORM_S = 2'd1;
    localparam logic [1:0] CFG_NORM_P = 2'd2;

    localparam int QDEPTH = 4;

    localparam logic [15:0] ZEFF_RST = 16'd4096;
    localparam logic [31:0] NORM_RST = 32'd328549;

endpackage

// File: sv/hoe_front.sv
module hoe_front (
    input  hoe_pkg::in_t  item,
    output hoe_pkg::cls_t cls
);

    logic [31:0] mx, my, mz;

    assign mx = item.q_x[31] ? (~item.q_x + 32'd1) : item.q_x;
    assign my = item.q_y[31] ? (~item.q_y + 32'd1) : item.q_y;
    assign mz = item.q_z[31] ? (~item.q_z + 32'd1) : item.q_z;

    always_comb
    begin
        cls.mag_x = mx;
        cls.mag_y = my;
        cls.mag_z = mz;
        cls.is_s  = 1'b0;
        cls.pneg  = 1'b0;
        cls.pmag  = 32'd0;
        unique case (item.orbital)
            hoe_pkg::ORB_2S:
            begin
                cls.is_s = 1'b1;
            end
            hoe_pkg::ORB_2PX:
            begin
                cls.pneg = item.q_x[31];
                cls.pmag = mx;
            end
            hoe_pkg::ORB_2PY:
            begin
                cls.pneg = item.q_y[31];
                cls.pmag = my;
            end
            hoe_pkg::ORB_2PZ:
            begin
                cls.pneg = item.q_z[31];
                cls.pmag = mz;
            end
            default:
            begin
                cls.is_s = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/hoe_queue.sv
`include "assert_macros.svh"

module hoe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hoe_pkg::cls_t wdata,
    input  logic          pop,
    output hoe_pkg::cls_t rdata,
    output logic          full,
    output logic          empty
);

    localparam int PW = $clog2(hoe_pkg::QDEPTH);
    localparam int CW = $clog2(hoe_pkg::QDEPTH + 1);

    hoe_pkg::cls_t mem_reg [hoe_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(hoe_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `HOE_ASSERT(a_q_bound, (count_reg <= CW'(hoe_pkg::QDEPTH)), "queue count out of range")
    `HOE_ASSERT_IMP(a_q_pop, pop, !empty, "pop from empty queue")
    `HOE_ASSERT_IMP(a_q_push, push, !full, "push into full queue")

endmodule

// File: sv/hoe_div.sv
module hoe_div #(
    parameter int NUMW = 176
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NUMW-1:0]    num,
    input  logic [191:0]       den,
    input  hoe_pkg::side_t     side_in,
    output logic               out_valid,
    output logic [32:0]        quo,
    output hoe_pkg::side_t     side_out
);

    // One restoring step per stage, quotient bit 32 down to bit 0.
    localparam int DW = ((NUMW > 225) ? NUMW : 225) + 1;
    localparam int NS = 33;

    logic [DW-1:0]  rem_reg  [NS];
    logic [191:0]   den_reg  [NS];
    logic [32:0]    quo_reg  [NS];
    hoe_pkg::side_t side_reg [NS];
    logic           v_reg    [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        localparam int K = NS - 1 - j;
        logic [DW-1:0]  rem_in;
        logic [191:0]   den_in;
        logic [32:0]    quo_in;
        hoe_pkg::side_t side_w;
        logic           v_in;
        logic [DW-1:0]  trial;
        logic           ge;

        if (j == 0)
        begin : g_first
            assign rem_in = DW'(num);
            assign den_in = den;
            assign quo_in = '0;
            assign side_w = side_in;
            assign v_in   = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign side_w = side_reg[j-1];
            assign v_in   = v_reg[j-1];
        end

        assign trial = DW'(den_in) << K;
        assign ge    = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? (rem_in - trial) : rem_in;
                den_reg[j]  <= den_in;
                quo_reg[j]  <= quo_in | (ge ? (33'd1 << K) : 33'd0);
                side_reg[j] <= side_w;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_in;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign quo       = quo_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

// File: sv/hoe_back.sv
`include "assert_macros.svh"

module hoe_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ent_valid,
    input  hoe_pkg::cls_t ent,
    output logic          ent_take,
    input  logic [15:0]   zeff,
    input  logic [31:0]   norm_s,
    input  logic [31:0]   norm_p,
    output logic          out_valid,
    input  logic          out_stall,
    output hoe_pkg::out_t out_data
);

    localparam int SH_S = 5 * FRAC_BITS - 16;
    localparam int SH_P = 6 * FRAC_BITS - 16;
    localparam int NUMW = 96 + SH_P;

    logic en;
    logic [8:1] v_reg;
    logic       out_valid_reg;
    hoe_pkg::out_t out_data_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign ent_take = en;

    // zeff^2/4 at 2*FRAC_BITS fraction bits
    logic [31:0] zsq;
    logic [63:0] h;
    assign zsq = zeff * zeff;
    if (2 * FRAC_BITS >= 26)
    begin : g_hl
        assign h = {32'd0, zsq} << (2 * FRAC_BITS - 26);
    end
    else
    begin : g_hr
        assign h = {32'd0, zsq} >> (26 - 2 * FRAC_BITS);
    end

    // stage 1: squares
    logic [63:0] sqx_reg, sqy_reg, sqz_reg;
    logic        s1_is_s_reg, s1_pneg_reg;
    logic [31:0] s1_pmag_reg;
    // stage 2: |q|^2
    logic [63:0] s_reg;
    logic        s2_is_s_reg, s2_pneg_reg;
    logic [31:0] s2_pmag_reg;
    // stage 3: d, numerator magnitude
    logic [63:0] d3_reg, nmag_reg;
    logic [31:0] norm_reg;
    logic        s3_is_s_reg;
    hoe_pkg::side_t s3_side_reg;
    // stage 4: partial products
    logic [63:0] dll_reg, dlh_reg, dhh_reg, nl_reg, nh_reg, d4_reg;
    logic        s4_is_s_reg;
    hoe_pkg::side_t s4_side_reg;
    // stage 5: d^2 and norm*nmag
    logic [127:0] d2_reg;
    logic [95:0]  np5_reg;
    logic [63:0]  d5_reg;
    logic         s5_is_s_reg;
    hoe_pkg::side_t s5_side_reg;
    // stage 6: d^2*d partials
    logic [63:0]  p_reg [4][2];
    logic [95:0]  np6_reg;
    logic         s6_is_s_reg;
    hoe_pkg::side_t s6_side_reg;
    // stage 7: row sums
    logic [159:0] r0_reg, r1_reg;
    logic [95:0]  np7_reg;
    logic         s7_is_s_reg;
    hoe_pkg::side_t s7_side_reg;
    // stage 8: divider operands
    logic [191:0]   den_reg;
    logic [NUMW-1:0] num_reg;
    hoe_pkg::side_t s8_side_reg;

    logic [159:0] r0_next, r1_next;
    always_comb
    begin
        r0_next = '0;
        r1_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            r0_next = r0_next + (160'(p_reg[i][0]) << (32 * i));
            r1_next = r1_next + (160'(p_reg[i][1]) << (32 * i));
        end
    end

    logic [63:0] d_next;
    assign d_next = s_reg + h;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg     <= ent.mag_x * ent.mag_x;
            sqy_reg     <= ent.mag_y * ent.mag_y;
            sqz_reg     <= ent.mag_z * ent.mag_z;
            s1_is_s_reg <= ent.is_s;
            s1_pneg_reg <= ent.pneg;
            s1_pmag_reg <= ent.pmag;

            s_reg       <= sqx_reg + sqy_reg + sqz_reg;
            s2_is_s_reg <= s1_is_s_reg;
            s2_pneg_reg <= s1_pneg_reg;
            s2_pmag_reg <= s1_pmag_reg;

            d3_reg           <= d_next;
            s3_is_s_reg      <= s2_is_s_reg;
            s3_side_reg.zero <= (d_next == 64'd0);
            if (s2_is_s_reg)
            begin
                s3_side_reg.rneg <= (s_reg < h);
                nmag_reg         <= (s_reg < h) ? (h - s_reg) : (s_reg - h);
                norm_reg         <= norm_s;
            end
            else
            begin
                s3_side_reg.rneg <= s2_pneg_reg;
                nmag_reg         <= {32'd0, s2_pmag_reg};
                norm_reg         <= norm_p;
            end

            dll_reg     <= d3_reg[31:0] * d3_reg[31:0];
            dlh_reg     <= d3_reg[31:0] * d3_reg[63:32];
            dhh_reg     <= d3_reg[63:32] * d3_reg[63:32];
            nl_reg      <= norm_reg * nmag_reg[31:0];
            nh_reg      <= norm_reg * nmag_reg[63:32];
            d4_reg      <= d3_reg;
            s4_is_s_reg <= s3_is_s_reg;
            s4_side_reg <= s3_side_reg;

            d2_reg      <= (128'(dhh_reg) << 64) + (128'(dlh_reg) << 33) + 128'(dll_reg);
            np5_reg     <= (96'(nh_reg) << 32) + 96'(nl_reg);
            d5_reg      <= d4_reg;
            s5_is_s_reg <= s4_is_s_reg;
            s5_side_reg <= s4_side_reg;

            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    p_reg[i][j] <= d2_reg[32*i +: 32] * d5_reg[32*j +: 32];
                end
            end
            np6_reg     <= np5_reg;
            s6_is_s_reg <= s5_is_s_reg;
            s6_side_reg <= s5_side_reg;

            r0_reg      <= r0_next;
            r1_reg      <= r1_next;
            np7_reg     <= np6_reg;
            s7_is_s_reg <= s6_is_s_reg;
            s7_side_reg <= s6_side_reg;

            den_reg     <= 192'(r0_reg) + (192'(r1_reg) << 32);
            num_reg     <= s7_is_s_reg ? (NUMW'(np7_reg) << SH_S)
                                       : (NUMW'(np7_reg) << SH_P);
            s8_side_reg <= s7_side_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[7:1], ent_valid};
        end
    end

    logic           dv_valid;
    logic [32:0]    dv_quo;
    hoe_pkg::side_t dv_side;

    hoe_div #(
        .NUMW(NUMW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v_reg[8]),
        .num      (num_reg),
        .den      (den_reg),
        .side_in  (s8_side_reg),
        .out_valid(dv_valid),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    // sign, saturation and the zero-denominator case
    hoe_pkg::out_t fmt;
    always_comb
    begin
        fmt.psi       = 32'sd0;
        fmt.saturated = 1'b0;
        if (dv_side.zero)
        begin
            fmt.psi = 32'sd0;
        end
        else if (dv_side.rneg)
        begin
            if (dv_quo[32] || (dv_quo[31:0] > 32'h8000_0000))
            begin
                fmt.psi       = 32'sh8000_0000;
                fmt.saturated = 1'b1;
            end
            else
            begin
                fmt.psi = ~dv_quo[31:0] + 32'd1;
            end
        end
        else
        begin
            if (dv_quo[32] || dv_quo[31])
            begin
                fmt.psi       = 32'sh7FFF_FFFF;
                fmt.saturated = 1'b1;
            end
            else
            begin
                fmt.psi = dv_quo[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= fmt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `HOE_ASSERT_IMP(a_sat_val, (out_valid_reg && out_data_reg.saturated),
        (out_data_reg.psi == 32'sh7FFF_FFFF || out_data_reg.psi == 32'sh8000_0000),
        "saturated result not at a rail")

endmodule

// File: sv/hydrogenic_orbital_momentum_eval.sv
// Momentum-space hydrogenic n=2 orbital evaluator (2s, 2px, 2py, 2pz).
// Input channel in_valid/in_stall/in_data: a transfer happens when in_valid
// is high and in_stall low; in_data carries q_x, q_y, q_z (signed, FRAC_BITS
// fraction bits) and the orbital select. Output channel out_valid/out_stall/
// out_data returns psi (saturated, signed, FRAC_BITS fraction bits) and the
// saturated flag, one result per item, in input order.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes zeff (0),
// norm_s (1) and norm_p (2); cfg_ready is always high and other indexes are
// dropped. Write registers only while no item is in flight.
// Throughput: one item per cycle while out_stall is low. An item passes the
// queue, 8 arithmetic stages (multiplies split in 32x32 pieces), the 33-stage
// restoring divider, one quotient bit per stage, and the output register.
// A stalled output freezes the whole back pipeline; the 4-entry queue
// behind the classifier keeps taking items until full, then in_stall rises.
// Reset: registers return to zeff=1.0, norm_s=norm_p=328549, pipeline empty.
module hydrogenic_orbital_momentum_eval #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  hoe_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output hoe_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    logic [15:0] zeff_reg;
    logic [31:0] norm_s_reg, norm_p_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zeff_reg   <= hoe_pkg::ZEFF_RST;
            norm_s_reg <= hoe_pkg::NORM_RST;
            norm_p_reg <= hoe_pkg::NORM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hoe_pkg::CFG_ZEFF:   zeff_reg   <= cfg_data[15:0];
                hoe_pkg::CFG_NORM_S: norm_s_reg <= cfg_data;
                hoe_pkg::CFG_NORM_P: norm_p_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Front: classify the item and queue it.
    hoe_pkg::cls_t cls, q_head;
    logic q_full, q_empty, take, push;

    hoe_front u_front (
        .item(in_data),
        .cls (cls)
    );

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    hoe_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(cls),
        .pop  (take && !q_empty),
        .rdata(q_head),
        .full (q_full),
        .empty(q_empty)
    );

    // Back: arithmetic pipeline, divider and output register.
    hoe_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ent_valid(!q_empty),
        .ent      (q_head),
        .ent_take (take),
        .zeff     (zeff_reg),
        .norm_s   (norm_s_reg),
        .norm_p   (norm_p_reg),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule
